[rtl/rti_pkg.sv]
package rti_pkg;

   localparam int COORD_BITS = 21;
   localparam int PACK_W     = 63;
   localparam int EDGE_W     = COORD_BITS + 1;
   localparam int CROSS_W    = 2 * EDGE_W + 1;
   localparam int PROD_W     = CROSS_W + EDGE_W;
   localparam int DOT_W      = PROD_W + 2;
   localparam int SDOT_W     = DOT_W + 1;
   localparam int MAG_W      = DOT_W;
   localparam int FRAC_W     = 16;
   localparam int QUO_W      = 32;
   localparam int BARY_W     = 17;
   localparam int TPROD_W    = QUO_W + COORD_BITS;
   localparam int TSUM_W     = TPROD_W + 2;
   localparam int LANES      = 3;

   localparam int LANE_U = 0;
   localparam int LANE_V = 1;
   localparam int LANE_T = 2;

   typedef logic [2:0][COORD_BITS-1:0] vec_type;

   typedef struct packed {
      logic [PACK_W-1:0] vertex_a;
      logic [PACK_W-1:0] vertex_b;
      logic [PACK_W-1:0] vertex_c;
      logic [PACK_W-1:0] ray_origin;
      logic [PACK_W-1:0] ray_direction;
      logic signed [31:0] t_min;
      logic signed [31:0] t_max;
   } req_type;

   typedef struct packed {
      logic hit;
      logic signed [31:0] hit_distance;
      logic [BARY_W-1:0] bary_u;
      logic [BARY_W-1:0] bary_v;
      logic [PACK_W-1:0] hit_point;
   } rsp_type;

   typedef struct packed {
      vec_type o;
      vec_type d;
      logic signed [31:0] t_min;
      logic signed [31:0] t_max;
   } side_type;

   typedef struct packed {
      logic signed [DOT_W-1:0] det;
      logic signed [DOT_W-1:0] nu;
      logic signed [DOT_W-1:0] nv;
      logic signed [DOT_W-1:0] nt;
   } dots_type;

   typedef struct packed {
      logic hit;
      logic tneg;
      logic tovf;
      logic rnz;
      logic [QUO_W-1:0] qu;
      logic [QUO_W-1:0] qv;
      logic [QUO_W-1:0] qt;
   } div_type;

   typedef struct packed {
      logic hit;
      logic tneg;
      logic tovf;
   } flag_type;

   function automatic vec_type unpack(input logic [PACK_W-1:0] w);
      return vec_type'(w[3*COORD_BITS-1:0]);
   endfunction

   function automatic logic signed [COORD_BITS-1:0] crd(input vec_type v, input int k);
      return $signed(v[k]);
   endfunction

   function automatic logic signed [CROSS_W-1:0] xmul(input logic signed [EDGE_W-1:0] a,
                                                      input logic signed [EDGE_W-1:0] b);
      return CROSS_W'(a) * CROSS_W'(b);
   endfunction

   function automatic logic signed [PROD_W-1:0] pmul(input logic signed [CROSS_W-1:0] a,
                                                     input logic signed [EDGE_W-1:0] b);
      return PROD_W'(a) * PROD_W'(b);
   endfunction

endpackage

[rtl/ray_triangle_intersect.sv]
// Two-sided Moller-Trumbore ray/triangle test, one ray and one triangle per
// beat. The block takes a new beat on every clock (busy is high only while
// reset is asserted) and returns exactly one result per beat, in order, on
// rsp_valid for a single cycle; the receiver cannot hold results off, so
// capture every rsp_valid cycle. The pipeline runs edge, cross and
// dot-product arithmetic, then sign folding and miss checks, then a
// pipelined restoring divider (one quotient bit per stage for u, v and t
// side by side), then stages that saturate t and form the rounded,
// saturated hit point. A miss returns hit low with all other fields zero.
// det_epsilon resets to 1; write it only while no beat is in flight.
module ray_triangle_intersect import rti_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  req_type     req_item,
   output logic        rsp_valid,
   output rsp_type     rsp_item,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [31:0] csr_wdata
);

   logic [31:0] eps_ff;

   logic     geo_valid;
   dots_type geo_dots;
   side_type geo_side;

   logic     div_valid;
   div_type  div_res;
   side_type div_side;

   // accept a beat whenever start is high outside reset
   assign busy      = reset;
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         eps_ff <= 32'd1;
      end else if (csr_valid && csr_ready) begin
         eps_ff <= csr_wdata;
      end
   end

   rti_geom u_geom (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (start && !busy),
      .in_req    (req_item),
      .out_valid (geo_valid),
      .out_dots  (geo_dots),
      .out_side  (geo_side)
   );

   rti_div u_div (
      .clock       (clock),
      .reset       (reset),
      .in_valid    (geo_valid),
      .in_dots     (geo_dots),
      .in_side     (geo_side),
      .det_epsilon (eps_ff),
      .out_valid   (div_valid),
      .out_div     (div_res),
      .out_side    (div_side)
   );

   rti_fin u_fin (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (div_valid),
      .in_div    (div_res),
      .in_side   (div_side),
      .out_valid (rsp_valid),
      .out_rsp   (rsp_item)
   );

endmodule

[rtl/rti_geom.sv]
module rti_geom import rti_pkg::*; (
   input  logic     clock,
   input  logic     reset,
   input  logic     in_valid,
   input  req_type  in_req,
   output logic     out_valid,
   output dots_type out_dots,
   output side_type out_side
);

   // stage 1: edges
   logic signed [EDGE_W-1:0] e1_in [3], e2_in [3], t3_in [3];
   logic signed [EDGE_W-1:0] e1_ff [3], e2_ff [3], t3_ff [3];
   side_type s1_in, s1_ff;
   logic v1_ff;

   always_comb begin
      vec_type a, b, c, o;
      a = unpack(in_req.vertex_a);
      b = unpack(in_req.vertex_b);
      c = unpack(in_req.vertex_c);
      o = unpack(in_req.ray_origin);
      for (int k = 0; k < 3; k++) begin
         e1_in[k] = EDGE_W'(crd(b, k)) - EDGE_W'(crd(a, k));
         e2_in[k] = EDGE_W'(crd(c, k)) - EDGE_W'(crd(a, k));
         t3_in[k] = EDGE_W'(crd(o, k)) - EDGE_W'(crd(a, k));
      end
      s1_in.o     = o;
      s1_in.d     = unpack(in_req.ray_direction);
      s1_in.t_min = in_req.t_min;
      s1_in.t_max = in_req.t_max;
   end

   // stage 2: P = D x E2, Q = T x E1
   logic signed [CROSS_W-1:0] p_in [3], q_in [3], p_ff [3], q_ff [3];
   logic signed [EDGE_W-1:0]  e1b_ff [3], e2b_ff [3], t3b_ff [3];
   side_type s2_ff;
   logic v2_ff;

   always_comb begin
      logic signed [EDGE_W-1:0] de [3];
      for (int k = 0; k < 3; k++) begin
         de[k] = EDGE_W'(crd(s1_ff.d, k));
      end
      p_in[0] = xmul(de[1], e2_ff[2]) - xmul(de[2], e2_ff[1]);
      p_in[1] = xmul(de[2], e2_ff[0]) - xmul(de[0], e2_ff[2]);
      p_in[2] = xmul(de[0], e2_ff[1]) - xmul(de[1], e2_ff[0]);
      q_in[0] = xmul(t3_ff[1], e1_ff[2]) - xmul(t3_ff[2], e1_ff[1]);
      q_in[1] = xmul(t3_ff[2], e1_ff[0]) - xmul(t3_ff[0], e1_ff[2]);
      q_in[2] = xmul(t3_ff[0], e1_ff[1]) - xmul(t3_ff[1], e1_ff[0]);
   end

   // stage 3: per-axis products of the four dot products
   logic signed [PROD_W-1:0] pe1_in [3], pt_in [3], qd_in [3], qe2_in [3];
   logic signed [PROD_W-1:0] pe1_ff [3], pt_ff [3], qd_ff [3], qe2_ff [3];
   side_type s3_ff;
   logic v3_ff;

   always_comb begin
      for (int k = 0; k < 3; k++) begin
         pe1_in[k] = pmul(p_ff[k], e1b_ff[k]);
         pt_in[k]  = pmul(p_ff[k], t3b_ff[k]);
         qd_in[k]  = pmul(q_ff[k], EDGE_W'(crd(s2_ff.d, k)));
         qe2_in[k] = pmul(q_ff[k], e2b_ff[k]);
      end
   end

   // stage 4: sum the axes
   dots_type dots_in, dots_ff;
   side_type s4_ff;
   logic v4_ff;

   always_comb begin
      dots_in.det = DOT_W'(pe1_ff[0]) + DOT_W'(pe1_ff[1]) + DOT_W'(pe1_ff[2]);
      dots_in.nu  = DOT_W'(pt_ff[0])  + DOT_W'(pt_ff[1])  + DOT_W'(pt_ff[2]);
      dots_in.nv  = DOT_W'(qd_ff[0])  + DOT_W'(qd_ff[1])  + DOT_W'(qd_ff[2]);
      dots_in.nt  = DOT_W'(qe2_ff[0]) + DOT_W'(qe2_ff[1]) + DOT_W'(qe2_ff[2]);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
      end else begin
         v1_ff <= in_valid;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
         v4_ff <= v3_ff;
      end
   end

   always_ff @(posedge clock) begin
      e1_ff   <= e1_in;
      e2_ff   <= e2_in;
      t3_ff   <= t3_in;
      s1_ff   <= s1_in;
      p_ff    <= p_in;
      q_ff    <= q_in;
      e1b_ff  <= e1_ff;
      e2b_ff  <= e2_ff;
      t3b_ff  <= t3_ff;
      s2_ff   <= s1_ff;
      pe1_ff  <= pe1_in;
      pt_ff   <= pt_in;
      qd_ff   <= qd_in;
      qe2_ff  <= qe2_in;
      s3_ff   <= s2_ff;
      dots_ff <= dots_in;
      s4_ff   <= s3_ff;
   end

   assign out_valid = v4_ff;
   assign out_dots  = dots_ff;
   assign out_side  = s4_ff;

endmodule

[rtl/rti_div.sv]
module rti_div import rti_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        in_valid,
   input  dots_type    in_dots,
   input  side_type    in_side,
   input  logic [31:0] det_epsilon,
   output logic        out_valid,
   output div_type     out_div,
   output side_type    out_side
);

   // sign stage: fold the determinant's sign into the numerators
   logic [MAG_W-1:0]         det_in, det_ff;
   logic signed [SDOT_W-1:0] nu_in, nv_in, nt_in, nu_ff, nv_ff, nt_ff;
   side_type sg_ff;
   logic sg_v_ff;

   always_comb begin
      logic neg;
      neg    = in_dots.det[DOT_W-1];
      det_in = MAG_W'(neg ? -in_dots.det : in_dots.det);
      nu_in  = neg ? -SDOT_W'(in_dots.nu) : SDOT_W'(in_dots.nu);
      nv_in  = neg ? -SDOT_W'(in_dots.nv) : SDOT_W'(in_dots.nv);
      nt_in  = neg ? -SDOT_W'(in_dots.nt) : SDOT_W'(in_dots.nt);
   end

   // division pipeline: entry 0 is the check stage
   logic [MAG_W-1:0] rem_ff [QUO_W+1][LANES];
   logic [QUO_W-1:0] lo_ff  [QUO_W+1][LANES];
   logic [QUO_W-1:0] quo_ff [QUO_W+1][LANES];
   logic [MAG_W-1:0] dv_ff  [QUO_W+1];
   flag_type         fl_ff  [QUO_W+1];
   side_type         sd_ff  [QUO_W+1];
   logic             vl_ff  [QUO_W+1];

   // check stage
   logic [MAG_W-1:0] rem0_in [LANES];
   logic [QUO_W-1:0] lo0_in  [LANES];
   flag_type         fl0_in;

   always_comb begin
      logic signed [SDOT_W-1:0] dets;
      logic signed [SDOT_W:0]   uv;
      logic [MAG_W-1:0]         mu, mv, mt;
      logic                     miss;
      dets = $signed({1'b0, det_ff});
      uv   = {nu_ff[SDOT_W-1], nu_ff} + {nv_ff[SDOT_W-1], nv_ff};
      miss = (det_ff == '0) || (det_ff < MAG_W'(det_epsilon))
          || nu_ff[SDOT_W-1] || (nu_ff > dets)
          || nv_ff[SDOT_W-1] || (nv_ff > dets)
          || (uv > $signed({2'b0, det_ff}));
      mu = MAG_W'(nu_ff);
      mv = MAG_W'(nv_ff);
      mt = MAG_W'(nt_ff[SDOT_W-1] ? -nt_ff : nt_ff);
      fl0_in.hit  = !miss;
      fl0_in.tneg = nt_ff[SDOT_W-1];
      fl0_in.tovf = {{FRAC_W{1'b0}}, mt} >= {det_ff, {FRAC_W{1'b0}}};
      rem0_in[LANE_U] = MAG_W'(mu >> FRAC_W);
      rem0_in[LANE_V] = MAG_W'(mv >> FRAC_W);
      rem0_in[LANE_T] = MAG_W'(mt >> FRAC_W);
      lo0_in[LANE_U]  = {mu[FRAC_W-1:0], {(QUO_W-FRAC_W){1'b0}}};
      lo0_in[LANE_V]  = {mv[FRAC_W-1:0], {(QUO_W-FRAC_W){1'b0}}};
      lo0_in[LANE_T]  = {mt[FRAC_W-1:0], {(QUO_W-FRAC_W){1'b0}}};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sg_v_ff  <= 1'b0;
         vl_ff[0] <= 1'b0;
      end else begin
         sg_v_ff  <= in_valid;
         vl_ff[0] <= sg_v_ff;
      end
   end

   always_ff @(posedge clock) begin
      det_ff    <= det_in;
      nu_ff     <= nu_in;
      nv_ff     <= nv_in;
      nt_ff     <= nt_in;
      sg_ff     <= in_side;
      rem_ff[0] <= rem0_in;
      lo_ff[0]  <= lo0_in;
      quo_ff[0] <= '{default: '0};
      dv_ff[0]  <= det_ff;
      fl_ff[0]  <= fl0_in;
      sd_ff[0]  <= sg_ff;
   end

   // one restoring quotient bit per stage, three lanes side by side
   for (genvar i = 0; i < QUO_W; i++) begin : g_step
      logic [MAG_W-1:0] rem_in [LANES];
      logic [QUO_W-1:0] lo_in  [LANES];
      logic [QUO_W-1:0] quo_in [LANES];

      always_comb begin
         logic [MAG_W:0] r2;
         logic           ge;
         for (int l = 0; l < LANES; l++) begin
            r2 = {rem_ff[i][l], lo_ff[i][l][QUO_W-1]};
            ge = r2 >= {1'b0, dv_ff[i]};
            rem_in[l] = ge ? MAG_W'(r2 - {1'b0, dv_ff[i]}) : MAG_W'(r2);
            lo_in[l]  = {lo_ff[i][l][QUO_W-2:0], 1'b0};
            quo_in[l] = {quo_ff[i][l][QUO_W-2:0], ge};
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            vl_ff[i+1] <= 1'b0;
         end else begin
            vl_ff[i+1] <= vl_ff[i];
         end
      end

      always_ff @(posedge clock) begin
         rem_ff[i+1] <= rem_in;
         lo_ff[i+1]  <= lo_in;
         quo_ff[i+1] <= quo_in;
         dv_ff[i+1]  <= dv_ff[i];
         fl_ff[i+1]  <= fl_ff[i];
         sd_ff[i+1]  <= sd_ff[i];
      end
   end

   assign out_valid    = vl_ff[QUO_W];
   assign out_side     = sd_ff[QUO_W];
   assign out_div.hit  = fl_ff[QUO_W].hit;
   assign out_div.tneg = fl_ff[QUO_W].tneg;
   assign out_div.tovf = fl_ff[QUO_W].tovf;
   assign out_div.rnz  = rem_ff[QUO_W][LANE_T] != '0;
   assign out_div.qu   = quo_ff[QUO_W][LANE_U];
   assign out_div.qv   = quo_ff[QUO_W][LANE_V];
   assign out_div.qt   = quo_ff[QUO_W][LANE_T];

endmodule

[rtl/rti_fin.sv]
module rti_fin import rti_pkg::*; (
   input  logic     clock,
   input  logic     reset,
   input  logic     in_valid,
   input  div_type  in_div,
   input  side_type in_side,
   output logic     out_valid,
   output rsp_type  out_rsp
);

   localparam int H_W = TSUM_W - FRAC_W;
   localparam logic signed [H_W-1:0] HMAX = H_W'((64'sd1 <<< (COORD_BITS - 1)) - 64'sd1);
   localparam logic signed [H_W-1:0] HMIN = -HMAX - H_W'(1);
   localparam logic signed [TSUM_W-1:0] HALF = TSUM_W'(1) << (FRAC_W - 1);
   localparam logic signed [31:0] T_POS_SAT = 32'sh7FFF_FFFF;
   localparam logic signed [31:0] T_NEG_SAT = 32'sh8000_0000;

   // stage 1: signed, saturated t and range test
   logic signed [31:0] t_in, t_ff;
   logic hit_in, hit_ff, v1_ff;
   logic [BARY_W-1:0] u_ff, w_ff;
   side_type s1_ff;

   always_comb begin
      logic [QUO_W:0] qq;
      qq = {1'b0, in_div.qt} + {{QUO_W{1'b0}}, in_div.rnz};
      if (in_div.tovf) begin
         t_in = in_div.tneg ? T_NEG_SAT : T_POS_SAT;
      end else if (!in_div.tneg) begin
         t_in = in_div.qt[QUO_W-1] ? T_POS_SAT : $signed(in_div.qt);
      end else begin
         t_in = (qq[QUO_W] || qq[QUO_W-1]) ? T_NEG_SAT : -$signed(qq[QUO_W-1:0]);
      end
      hit_in = in_div.hit && !(t_in < in_side.t_min) && !(t_in > in_side.t_max);
   end

   // stage 2: t times direction
   logic signed [TPROD_W-1:0] pr_in [3], pr_ff [3];
   logic signed [31:0] t2_ff;
   logic hit2_ff, v2_ff;
   logic [BARY_W-1:0] u2_ff, w2_ff;
   vec_type o2_ff;

   always_comb begin
      for (int k = 0; k < 3; k++) begin
         pr_in[k] = TPROD_W'(t_ff) * TPROD_W'(crd(s1_ff.d, k));
      end
   end

   // stage 3: add origin, round, saturate, pack
   rsp_type rsp_in, rsp_ff;
   logic v3_ff;

   always_comb begin
      logic signed [TSUM_W-1:0] s;
      logic signed [H_W-1:0]    h;
      logic [PACK_W-1:0]        hp;
      hp = '0;
      for (int k = 0; k < 3; k++) begin
         s = (TSUM_W'(crd(o2_ff, k)) <<< FRAC_W) + TSUM_W'(pr_ff[k]) + HALF;
         h = $signed(s[TSUM_W-1:FRAC_W]);
         if (h > HMAX) begin
            h = HMAX;
         end else if (h < HMIN) begin
            h = HMIN;
         end
         hp[k*COORD_BITS +: COORD_BITS] = h[COORD_BITS-1:0];
      end
      rsp_in.hit          = hit2_ff;
      rsp_in.hit_distance = hit2_ff ? t2_ff : '0;
      rsp_in.bary_u       = hit2_ff ? u2_ff : '0;
      rsp_in.bary_v       = hit2_ff ? w2_ff : '0;
      rsp_in.hit_point    = hit2_ff ? hp : '0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
      end else begin
         v1_ff <= in_valid;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
      end
   end

   always_ff @(posedge clock) begin
      t_ff    <= t_in;
      hit_ff  <= hit_in;
      u_ff    <= in_div.qu[BARY_W-1:0];
      w_ff    <= in_div.qv[BARY_W-1:0];
      s1_ff   <= in_side;
      pr_ff   <= pr_in;
      t2_ff   <= t_ff;
      hit2_ff <= hit_ff;
      u2_ff   <= u_ff;
      w2_ff   <= w_ff;
      o2_ff   <= s1_ff.o;
      rsp_ff  <= rsp_in;
   end

   assign out_valid = v3_ff;
   assign out_rsp   = rsp_ff;

endmodule

[tb/ray_triangle_intersect_tb.sv]
module ray_triangle_intersect_tb;
   import rti_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   typedef logic signed [127:0] wide_type;

   localparam int  CYCLE_LIMIT = 400000;
   localparam longint CRD_MAX  = (64'sd1 <<< (COORD_BITS - 1)) - 1;
   localparam longint CRD_MIN  = -CRD_MAX - 1;

   // Expected hit records, in issue order, plus the predictor that fills them.
   class hit_scoreboard;
      rsp_type     expected_hits[$];
      logic [31:0] det_eps = 32'd1;
      int          mismatches = 0;
      int          hits_seen = 0;
      int          misses_seen = 0;

      function longint coord(logic [PACK_W-1:0] w, int k);
         logic signed [COORD_BITS-1:0] c;
         c = w[k*COORD_BITS +: COORD_BITS];
         return longint'(c);
      endfunction

      function rsp_type trace_ray(req_type r);
         longint a[3], b[3], c[3], o[3], d[3], e1[3], e2[3], tv[3], p[3], q[3];
         wide_type det, nu, nv, nt, mag, qu, qv, qt;
         bit     rnz, tneg;
         longint t, tmin, tmax, s, h;
         rsp_type res;
         res = '0;
         for (int k = 0; k < 3; k++) begin
            a[k] = coord(r.vertex_a, k);
            b[k] = coord(r.vertex_b, k);
            c[k] = coord(r.vertex_c, k);
            o[k] = coord(r.ray_origin, k);
            d[k] = coord(r.ray_direction, k);
            e1[k] = b[k] - a[k];
            e2[k] = c[k] - a[k];
            tv[k] = o[k] - a[k];
         end
         p[0] = d[1]*e2[2] - d[2]*e2[1];
         p[1] = d[2]*e2[0] - d[0]*e2[2];
         p[2] = d[0]*e2[1] - d[1]*e2[0];
         q[0] = tv[1]*e1[2] - tv[2]*e1[1];
         q[1] = tv[2]*e1[0] - tv[0]*e1[2];
         q[2] = tv[0]*e1[1] - tv[1]*e1[0];
         det = 0; nu = 0; nv = 0; nt = 0;
         for (int k = 0; k < 3; k++) begin
            det += wide_type'(p[k]) * wide_type'(e1[k]);
            nu  += wide_type'(p[k]) * wide_type'(tv[k]);
            nv  += wide_type'(q[k]) * wide_type'(d[k]);
            nt  += wide_type'(q[k]) * wide_type'(e2[k]);
         end
         // fold the sign so the determinant is positive (two-sided test)
         if (det < 0) begin
            det = -det; nu = -nu; nv = -nv; nt = -nt;
         end
         if (det == 0 || det < wide_type'({96'b0, det_eps})) return res;
         if (nu < 0 || nu > det) return res;
         if (nv < 0 || nv > det) return res;
         if (nu + nv > det) return res;
         qu = (nu <<< FRAC_W) / det;
         qv = (nv <<< FRAC_W) / det;
         tneg = nt < 0;
         mag = tneg ? -nt : nt;
         qt = (mag <<< FRAC_W) / det;
         rnz = ((mag <<< FRAC_W) % det) != 0;
         if (!tneg) begin
            t = (qt > 128'sh7FFFFFFF) ? 64'sh7FFFFFFF : longint'(qt);
         end else begin
            if (rnz) qt = qt + 1;
            t = (qt >= 128'sh80000000) ? -64'sh80000000 : -longint'(qt);
         end
         tmin = longint'(r.t_min);
         tmax = longint'(r.t_max);
         if (t < tmin || t > tmax) return res;
         res.hit = 1'b1;
         res.hit_distance = t[31:0];
         res.bary_u = qu[BARY_W-1:0];
         res.bary_v = qv[BARY_W-1:0];
         for (int k = 0; k < 3; k++) begin
            s = o[k] * 65536 + t * d[k] + 32768;
            h = s >>> 16;
            if (h > CRD_MAX) h = CRD_MAX;
            if (h < CRD_MIN) h = CRD_MIN;
            res.hit_point[k*COORD_BITS +: COORD_BITS] = h[COORD_BITS-1:0];
         end
         return res;
      endfunction

      function void note_ray(req_type r);
         expected_hits.push_back(trace_ray(r));
      endfunction

      function void check_result(rsp_type got);
         rsp_type want;
         if (expected_hits.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected result beat %p", got);
            return;
         end
         want = expected_hits.pop_front();
         if (got.hit) hits_seen++; else misses_seen++;
         if (got !== want) begin
            mismatches++;
            if (mismatches <= 10) begin
               $display("mismatch: hit %b/%b t %h/%h u %h/%h v %h/%h pt %h/%h",
                        want.hit, got.hit, want.hit_distance, got.hit_distance,
                        want.bary_u, got.bary_u, want.bary_v, got.bary_v,
                        want.hit_point, got.hit_point);
            end
         end
      endfunction
   endclass

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        start = 1'b0;
   logic        busy;
   req_type     req_item = '0;
   logic        rsp_valid;
   rsp_type     rsp_item;
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic [31:0] csr_wdata = '0;

   hit_scoreboard sb = new();
   int cycles = 0;
   int beats_sent = 0;
   bit no_gaps = 1'b0;

   ray_triangle_intersect dut (
      .clock(clock), .reset(reset), .start(start), .busy(busy), .req_item(req_item),
      .rsp_valid(rsp_valid), .rsp_item(rsp_item),
      .csr_valid(csr_valid), .csr_ready(csr_ready), .csr_wdata(csr_wdata)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Results cannot be stalled, so capture every strobed cycle.
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (!reset && rsp_valid) sb.check_result(rsp_item);
   end

   // Hard stop in case the block hangs.
   always @(posedge clock) begin
      if (cycles > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles", cycles);
         $display("TEST FAILED");
         $finish;
      end
   end

   function automatic logic [PACK_W-1:0] pack3(longint x, longint y, longint z);
      return {z[COORD_BITS-1:0], y[COORD_BITS-1:0], x[COORD_BITS-1:0]};
   endfunction

   function automatic longint rnd_crd(int span);
      return longint'($urandom_range(0, 2 * span)) - span;
   endfunction

   // Drive one beat, hold it until accepted, then maybe idle for a while.
   task automatic send_ray(req_type r);
      start <= 1'b1;
      req_item <= r;
      do @(posedge clock); while (busy);
      sb.note_ray(r);
      beats_sent++;
      if (!no_gaps && $urandom_range(0, 99) < 10) begin
         start <= 1'b0;
         repeat ($urandom_range(1, 6)) @(posedge clock);
      end
   endtask

   // Drain all results, let the pipe settle, then write the epsilon register.
   task automatic write_epsilon(logic [31:0] value);
      start <= 1'b0;
      while (sb.expected_hits.size() != 0) @(posedge clock);
      repeat (50) @(posedge clock);
      csr_valid <= 1'b1;
      csr_wdata <= value;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      sb.det_eps = value;
   endtask

   // Build a ray aimed at a weighted point of a random triangle; weights past
   // 256 land outside the triangle.
   function automatic req_type aimed_ray(int wmax, bit flat);
      req_type r;
      longint a[3], b[3], c[3], o[3], tg[3];
      int u, v, span, div;
      span = (1 << $urandom_range(4, 18));
      u = $urandom_range(0, wmax);
      v = $urandom_range(0, (wmax > u) ? wmax - u : 0);
      div = $urandom_range(1, 3);
      for (int k = 0; k < 3; k++) begin
         a[k] = rnd_crd(span);
         b[k] = rnd_crd(span);
         c[k] = rnd_crd(span);
         o[k] = rnd_crd(span);
         tg[k] = a[k] + ((b[k] - a[k]) * u + (c[k] - a[k]) * v) / 256;
      end
      r.vertex_a = pack3(a[0], a[1], a[2]);
      r.vertex_b = pack3(b[0], b[1], b[2]);
      r.vertex_c = pack3(c[0], c[1], c[2]);
      r.ray_origin = pack3(o[0], o[1], o[2]);
      if (flat) r.ray_direction = pack3(b[0]-a[0], b[1]-a[1], b[2]-a[2]);
      else r.ray_direction = pack3((tg[0]-o[0])/div, (tg[1]-o[1])/div, (tg[2]-o[2])/div);
      case ($urandom_range(0, 9))
         0: begin r.t_min = $urandom; r.t_max = $urandom; end
         1: begin r.t_min = 32'sh00010000 * div + 1; r.t_max = 32'sh7FFFFFFF; end
         2: begin r.t_min = 32'sh80000000; r.t_max = 32'sh00010000 * div - 1; end
         3: begin r.t_min = 32'sh7FFFFFFF; r.t_max = 32'sh80000000; end
         default: begin r.t_min = 32'sh80000000 + $urandom_range(0, 1000); r.t_max = 32'sh7FFFFFFF; end
      endcase
      return r;
   endfunction

   function automatic req_type noise_ray();
      req_type r;
      r.vertex_a = PACK_W'({$urandom, $urandom});
      r.vertex_b = PACK_W'({$urandom, $urandom});
      r.vertex_c = PACK_W'({$urandom, $urandom});
      r.ray_origin = PACK_W'({$urandom, $urandom});
      r.ray_direction = PACK_W'({$urandom, $urandom});
      r.t_min = $urandom_range(0, 1) ? 32'sh80000000 : $urandom;
      r.t_max = $urandom_range(0, 1) ? 32'sh7FFFFFFF : $urandom;
      return r;
   endfunction

   // Fixed triangle with a unit ray straight down onto it.
   function automatic req_type base_ray();
      req_type r;
      r.vertex_a = pack3(0, 0, 0);
      r.vertex_b = pack3(1024, 0, 0);
      r.vertex_c = pack3(0, 1024, 0);
      r.ray_origin = pack3(256, 256, 1024);
      r.ray_direction = pack3(0, 0, -1024);
      r.t_min = 32'sh80000000;
      r.t_max = 32'sh7FFFFFFF;
      return r;
   endfunction

   task automatic run_directed();
      req_type r;
      r = '0;
      send_ray(r);                                 // all zero: zero determinant
      r = '1;
      send_ray(r);                                 // all ones
      r = base_ray();
      send_ray(r);                                 // plain hit at t = 1
      r.vertex_b = pack3(0, 1024, 0);
      r.vertex_c = pack3(1024, 0, 0);
      send_ray(r);                                 // back face, negative det
      r = base_ray();
      r.t_min = 32'sh00020000; r.t_max = 0;
      send_ray(r);                                 // reversed range
      r = base_ray();
      r.ray_origin = pack3(256, 256, CRD_MAX);
      r.ray_direction = pack3(1, -1, -1);
      send_ray(r);                                 // huge t, but the ray lands outside: miss
      r.t_max = 32'sh7FFFFFFE;
      send_ray(r);                                 // same, just below the extreme
      r = base_ray();
      r.ray_origin = pack3(1024, 0, 1024);
      send_ray(r);                                 // exactly on a vertex, u = 1
      r.ray_origin = pack3(0, 0, 1024);
      send_ray(r);                                 // other corner, u = v = 0
      r.ray_origin = pack3(512, 512, 1024);
      send_ray(r);                                 // on the far edge, u + v = 1
      r.ray_origin = pack3(513, 512, 1024);
      send_ray(r);                                 // just past it
      r = base_ray();
      r.ray_direction = pack3(1024, 0, 0);
      send_ray(r);                                 // parallel ray
      r = base_ray();
      r.ray_origin = pack3(256, 256, -1024);
      send_ray(r);                                 // behind origin, negative t
      r.ray_origin = pack3(300, 200, -1000);
      r.ray_direction = pack3(7, 3, -3000);
      send_ray(r);                                 // negative t with remainder
      r.vertex_a = pack3(CRD_MIN, CRD_MIN, CRD_MIN);
      r.vertex_b = pack3(CRD_MAX, CRD_MIN, CRD_MAX);
      r.vertex_c = pack3(CRD_MIN, CRD_MAX, CRD_MAX);
      r.ray_origin = pack3(CRD_MAX, CRD_MAX, CRD_MIN);
      r.ray_direction = pack3(CRD_MIN, CRD_MIN, CRD_MAX);
      r.t_min = 32'sh80000000; r.t_max = 32'sh7FFFFFFF;
      send_ray(r);                                 // extreme coordinates
   endtask

   task automatic run_random(int count);
      int pick;
      for (int i = 0; i < count; i++) begin
         no_gaps = (i >= count / 3) && (i < count / 3 + 60);
         pick = $urandom_range(0, 99);
         if (pick < 65) send_ray(aimed_ray(256, 1'b0));
         else if (pick < 80) send_ray(aimed_ray(420, 1'b0));
         else if (pick < 85) send_ray(aimed_ray(256, 1'b1));
         else send_ray(noise_ray());
      end
      no_gaps = 1'b0;
   endtask

   initial begin
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      write_epsilon(32'd1);
      run_directed();
      run_random(250);
      write_epsilon(32'd0);
      send_ray(base_ray());
      run_random(200);
      write_epsilon(32'hFFFFFFFF);
      run_random(150);
      write_epsilon($urandom);
      run_random(150);
      write_epsilon(32'd1 << $urandom_range(8, 31));
      run_random(100);
      start <= 1'b0;
      while (sb.expected_hits.size() != 0) @(posedge clock);
      repeat (60) @(posedge clock);
      $display("%0d rays sent over five epsilon settings, %0d hits and %0d misses returned",
               beats_sent, sb.hits_seen, sb.misses_seen);
      if (sb.mismatches == 0 && sb.expected_hits.size() == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("%0d mismatches", sb.mismatches);
         $display("TEST FAILED");
      end
      $finish;
   end

endmodule
